/* src/vsc_pkg.sv */
`timescale 1ns / 1ps

package vsc_pkg;

  localparam int VSC_QUEUE_DEPTH = 4;

  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_NINE = 8'h39;

  typedef enum logic [1:0] {
    CLS_OTHER,
    CLS_NONZERO,
    CLS_ZERO
  } cls_t;

  // context base, the upper two bits of the table index
  typedef enum logic [1:0] {
    CTX_NORMAL,
    CTX_INTEGRAL,
    CTX_FRACTION,
    CTX_LEADZERO
  } ctx_t;

  typedef enum logic [1:0] {
    DEC_CMP,
    DEC_LEN,
    DEC_NEG,
    DEC_POS
  } dec_t;

  typedef struct packed {
    cls_t              class_a;
    cls_t              class_b;
    logic              digit_a;
    logic              digit_b;
    logic              same_char;
    logic signed [8:0] diff;
  } vsc_item_t;

  // index: {context, class of char_a}
  localparam ctx_t CTX_NEXT [16] = '{
    CTX_NORMAL, CTX_INTEGRAL, CTX_LEADZERO, CTX_NORMAL,
    CTX_NORMAL, CTX_INTEGRAL, CTX_INTEGRAL, CTX_INTEGRAL,
    CTX_NORMAL, CTX_FRACTION, CTX_FRACTION, CTX_FRACTION,
    CTX_NORMAL, CTX_FRACTION, CTX_LEADZERO, CTX_LEADZERO
  };

  // index: {context, class of char_a, class of char_b}
  localparam dec_t DECIDE [64] = '{
    DEC_CMP, DEC_CMP, DEC_CMP, DEC_CMP, DEC_CMP, DEC_LEN, DEC_CMP, DEC_CMP,
    DEC_CMP, DEC_CMP, DEC_CMP, DEC_CMP, DEC_CMP, DEC_CMP, DEC_CMP, DEC_CMP,
    DEC_CMP, DEC_NEG, DEC_NEG, DEC_CMP, DEC_POS, DEC_LEN, DEC_LEN, DEC_CMP,
    DEC_POS, DEC_LEN, DEC_LEN, DEC_CMP, DEC_CMP, DEC_CMP, DEC_CMP, DEC_CMP,
    DEC_CMP, DEC_CMP, DEC_CMP, DEC_CMP, DEC_CMP, DEC_LEN, DEC_CMP, DEC_CMP,
    DEC_CMP, DEC_CMP, DEC_CMP, DEC_CMP, DEC_CMP, DEC_CMP, DEC_CMP, DEC_CMP,
    DEC_CMP, DEC_POS, DEC_POS, DEC_CMP, DEC_NEG, DEC_CMP, DEC_CMP, DEC_CMP,
    DEC_NEG, DEC_CMP, DEC_CMP, DEC_CMP, DEC_CMP, DEC_CMP, DEC_CMP, DEC_CMP
  };

endpackage

/* src/vsc_front.sv */
`timescale 1ns / 1ps

module vsc_front
  import vsc_pkg::*;
(
  input  logic [7:0] char_a,
  input  logic [7:0] char_b,
  output vsc_item_t  item
);

  logic digit_a;
  logic digit_b;

  assign digit_a = (char_a >= DIGIT_ZERO) && (char_a <= DIGIT_NINE);
  assign digit_b = (char_b >= DIGIT_ZERO) && (char_b <= DIGIT_NINE);

  always_comb begin
    item.digit_a   = digit_a;
    item.digit_b   = digit_b;
    item.same_char = (char_a == char_b) && (char_a != 8'd0);
    item.diff      = $signed({1'b0, char_a} - {1'b0, char_b});
    if (char_a == DIGIT_ZERO) begin
      item.class_a = CLS_ZERO;
    end else if (digit_a) begin
      item.class_a = CLS_NONZERO;
    end else begin
      item.class_a = CLS_OTHER;
    end
    if (char_b == DIGIT_ZERO) begin
      item.class_b = CLS_ZERO;
    end else if (digit_b) begin
      item.class_b = CLS_NONZERO;
    end else begin
      item.class_b = CLS_OTHER;
    end
  end

endmodule

/* src/vsc_queue.sv */
`timescale 1ns / 1ps

module vsc_queue
  import vsc_pkg::*;
#(
  parameter int Depth = VSC_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  vsc_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output vsc_item_t pop_item
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  vsc_item_t       entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full      = (count == CntW'(Depth));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("queue count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> wr_ptr == rd_ptr)
    else $error("empty queue with unequal pointers");

endmodule

/* src/vsc_back.sv */
`timescale 1ns / 1ps

module vsc_back
  import vsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  vsc_item_t         item,
  output logic              pop,
  output logic signed [8:0] order,
  output logic              order_valid,
  input  logic              order_ready
);

  ctx_t              context_state;
  ctx_t              context_state_next;
  logic              length_phase;
  logic              length_phase_next;
  logic signed [8:0] saved_difference;
  logic signed [8:0] saved_difference_next;
  logic              res_valid;
  logic signed [8:0] res_value;
  logic              order_valid_next;
  logic [3:0]        st;
  dec_t              dec;

  assign pop = item_valid && (!order_valid || order_ready);
  assign st  = {context_state, item.class_a};
  assign dec = DECIDE[{st, item.class_b}];

  always_comb begin
    res_valid             = 1'b0;
    res_value             = '0;
    context_state_next    = context_state;
    length_phase_next     = length_phase;
    saved_difference_next = saved_difference;
    if (length_phase) begin
      // decide by which digit run ends first
      if (item.digit_a) begin
        if (!item.digit_b) begin
          res_valid = 1'b1;
          res_value = 9'sd1;
        end
      end else if (item.digit_b) begin
        res_valid = 1'b1;
        res_value = -9'sd1;
      end else begin
        res_valid = 1'b1;
        res_value = saved_difference;
      end
    end else if (item.same_char) begin
      context_state_next = CTX_NEXT[st];
    end else begin
      unique case (dec)
        DEC_CMP: begin
          res_valid = 1'b1;
          res_value = item.diff;
        end
        DEC_LEN: begin
          length_phase_next     = 1'b1;
          saved_difference_next = item.diff;
        end
        DEC_NEG: begin
          res_valid = 1'b1;
          res_value = -9'sd1;
        end
        DEC_POS: begin
          res_valid = 1'b1;
          res_value = 9'sd1;
        end
        default: begin
          res_valid = 1'b1;
          res_value = item.diff;
        end
      endcase
    end
    // a result ends the comparison
    if (res_valid) begin
      context_state_next    = CTX_NORMAL;
      length_phase_next     = 1'b0;
      saved_difference_next = '0;
    end
  end

  assign order_valid_next = (pop && res_valid) || (order_valid && !order_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      context_state    <= CTX_NORMAL;
      length_phase     <= 1'b0;
      saved_difference <= '0;
      order_valid      <= 1'b0;
    end else begin
      if (pop) begin
        context_state    <= context_state_next;
        length_phase     <= length_phase_next;
        saved_difference <= saved_difference_next;
      end
      order_valid <= order_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      order <= res_value;
    end
  end

  a_result_clears: assert property (@(posedge clk) disable iff (rst)
    pop && res_valid |=> context_state == CTX_NORMAL && !length_phase)
    else $error("context not cleared after result");

  a_saved_idle: assert property (@(posedge clk) disable iff (rst)
    !length_phase |-> saved_difference == '0)
    else $error("saved difference held outside length phase");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    pop && res_valid |=> order_valid && order == $past(res_value))
    else $error("result not presented");

endmodule

/* src/version_string_compare.sv */
`timescale 1ns / 1ps

// Compares two NUL-terminated version strings in version order, one character
// pair per transaction on char_a/char_b. A result on order (negative, zero or
// positive) comes out at the first differing pair, at a shared terminator, or
// once a digit run length is settled; pairs that decide nothing give no result,
// and the pair after a result starts a new comparison. The block takes one pair
// per clock cycle while the queue has room: the front classifies a pair and
// queues it in the cycle it is taken, and the back updates the context once
// per cycle unless order stalls; a result passes the queue and then the order
// register. A stall on order fills the queue and then holds off char_ready.

module version_string_compare
  import vsc_pkg::*;
#(
  parameter int QueueDepth = VSC_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              char_valid,
  output logic              char_ready,
  input  logic [7:0]        char_a,
  input  logic [7:0]        char_b,
  output logic              order_valid,
  input  logic              order_ready,
  output logic signed [8:0] order
);

  vsc_item_t front_item;
  vsc_item_t queue_item;
  logic      queue_full;
  logic      queue_not_empty;
  logic      queue_pop;

  assign char_ready = !queue_full;

  vsc_front u_front (
    .char_a (char_a),
    .char_b (char_b),
    .item   (front_item)
  );

  vsc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (char_valid),
    .push_item (front_item),
    .full      (queue_full),
    .pop       (queue_pop),
    .not_empty (queue_not_empty),
    .pop_item  (queue_item)
  );

  vsc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (queue_not_empty),
    .item        (queue_item),
    .pop         (queue_pop),
    .order       (order),
    .order_valid (order_valid),
    .order_ready (order_ready)
  );

endmodule

/* bench/tb_version_string_compare.sv */
`timescale 1ns / 1ps

module tb_version_string_compare;
  import vsc_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              char_valid  = 1'b0;
  logic              char_ready;
  logic [7:0]        char_a      = '0;
  logic [7:0]        char_b      = '0;
  logic              order_valid;
  logic              order_ready = 1'b0;
  logic signed [8:0] order;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int pairs_sent    = 0;
  int error_count   = 0;
  bit pair_decided;

  logic signed [8:0] pending_orders[$];
  logic signed [8:0] oldest_order;

  // comparison state mirrored from the block
  bit                cmp_fresh       = 1'b1;
  ctx_t              cmp_ctx         = CTX_NORMAL;
  bit                run_length_mode = 1'b0;
  logic signed [8:0] held_diff       = '0;

  version_string_compare dut (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .char_a      (char_a),
    .char_b      (char_b),
    .order_valid (order_valid),
    .order_ready (order_ready),
    .order       (order)
  );

  always #5 clk = ~clk;

  function automatic bit is_digit(logic [7:0] c);
    return c >= DIGIT_ZERO && c <= DIGIT_NINE;
  endfunction

  function automatic cls_t classify(logic [7:0] c);
    if (c == DIGIT_ZERO) return CLS_ZERO;
    if (is_digit(c)) return CLS_NONZERO;
    return CLS_OTHER;
  endfunction

  // context after a matching character of class ca
  function automatic ctx_t next_context(ctx_t ctx, cls_t ca);
    if (ca == CLS_OTHER) return CTX_NORMAL;
    case (ctx)
      CTX_NORMAL:   return (ca == CLS_ZERO) ? CTX_LEADZERO : CTX_INTEGRAL;
      CTX_LEADZERO: return (ca == CLS_ZERO) ? CTX_LEADZERO : CTX_FRACTION;
      default:      return ctx;
    endcase
  endfunction

  // what to do at the first mismatching pair
  function automatic dec_t decide_pair(ctx_t ctx, cls_t ca, cls_t cb);
    case (ctx)
      CTX_INTEGRAL: begin
        if (ca == CLS_OTHER) return (cb == CLS_OTHER) ? DEC_CMP : DEC_NEG;
        return (cb == CLS_OTHER) ? DEC_POS : DEC_LEN;
      end
      CTX_LEADZERO: begin
        if (ca == CLS_OTHER) return (cb == CLS_OTHER) ? DEC_CMP : DEC_POS;
        return (cb == CLS_OTHER) ? DEC_NEG : DEC_CMP;
      end
      default: return (ca == CLS_NONZERO && cb == CLS_NONZERO) ? DEC_LEN : DEC_CMP;
    endcase
  endfunction

  // advances the mirrored comparison by one pair, returns 1 when an order is due
  function automatic bit step_compare(input logic [7:0] a, input logic [7:0] b,
                                      output logic signed [8:0] verdict);
    logic signed [8:0] diff;
    bit                decided;
    diff    = {1'b0, a} - {1'b0, b};
    decided = 1'b0;
    verdict = '0;
    if (run_length_mode) begin
      // the digit run that ends first is the smaller number
      decided = 1'b1;
      if (is_digit(a)) begin
        if (is_digit(b)) decided = 1'b0;
        else verdict = 9'sd1;
      end else if (is_digit(b)) begin
        verdict = -9'sd1;
      end else begin
        verdict = held_diff;
      end
    end else begin
      if (cmp_fresh) begin
        cmp_ctx   = CTX_NORMAL;
        cmp_fresh = 1'b0;
      end
      if (a == b && a != 8'h00) begin
        cmp_ctx = next_context(cmp_ctx, classify(a));
      end else begin
        case (decide_pair(cmp_ctx, classify(a), classify(b)))
          DEC_LEN: begin
            run_length_mode = 1'b1;
            held_diff       = diff;
          end
          DEC_NEG: begin
            decided = 1'b1;
            verdict = -9'sd1;
          end
          DEC_POS: begin
            decided = 1'b1;
            verdict = 9'sd1;
          end
          default: begin
            decided = 1'b1;
            verdict = diff;
          end
        endcase
      end
    end
    if (decided) begin
      cmp_fresh       = 1'b1;
      cmp_ctx         = CTX_NORMAL;
      run_length_mode = 1'b0;
      held_diff       = '0;
    end
    return decided;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // one character pair transaction; prediction is made as valid goes up
  task automatic send_pair(input logic [7:0] a, input logic [7:0] b);
    logic signed [8:0] predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid <= 1'b1;
    char_a     <= a;
    char_b     <= b;
    pair_decided = step_compare(a, b, predicted);
    if (pair_decided) pending_orders.push_back(predicted);
    do @(posedge clk); while (!char_ready);
    pairs_sent++;
  endtask

  task automatic hold_sender();
    @(negedge clk);
    char_valid <= 1'b0;
  endtask

  function automatic byte_q_t to_bytes(input string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // sends pairs position by position until the block owes an order
  task automatic compare_versions(input byte_q_t sa, input byte_q_t sb);
    int         i;
    logic [7:0] a;
    logic [7:0] b;
    i = 0;
    do begin
      a = (i < sa.size()) ? sa[i] : 8'h00;
      b = (i < sb.size()) ? sb[i] : 8'h00;
      send_pair(a, b);
      i++;
    end while (!pair_decided);
  endtask

  function automatic byte_q_t random_version(input int max_len);
    byte_q_t q;
    int      n;
    int      pick;
    n = $urandom_range(max_len);
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 20)      q.push_back(DIGIT_ZERO);
      else if (pick < 60) q.push_back(8'($urandom_range(8'h31, 8'h39)));
      else if (pick < 78) q.push_back(".");
      else if (pick < 92) q.push_back(8'($urandom_range(8'h61, 8'h7a)));
      else                q.push_back(8'($urandom_range(1, 255)));
    end
    return q;
  endfunction

  task automatic random_comparison();
    byte_q_t sa;
    byte_q_t sb;
    byte_q_t tail;
    int      keep;
    sa   = random_version(8);
    keep = $urandom_range(sa.size());
    for (int i = 0; i < keep; i++) sb.push_back(sa[i]);
    // mostly a shared prefix with a new tail, sometimes identical strings
    if (keep != sa.size() || $urandom_range(99) < 70) begin
      tail = random_version(4);
      foreach (tail[i]) sb.push_back(tail[i]);
    end
    if ($urandom_range(1)) compare_versions(sa, sb);
    else compare_versions(sb, sa);
  endtask

  task automatic test_ends_and_extremes();
    compare_versions(to_bytes(""), to_bytes(""));
    send_pair(8'hff, 8'h00);
    send_pair(8'h00, 8'hff);
  endtask

  task automatic test_digit_runs();
    compare_versions(to_bytes("9"), to_bytes("10"));
    compare_versions(to_bytes("10"), to_bytes("9"));
    compare_versions(to_bytes("12"), to_bytes("13"));
  endtask

  task automatic test_leading_zeros();
    compare_versions(to_bytes("0"), to_bytes("00"));
    compare_versions(to_bytes("01"), to_bytes("0"));
    compare_versions(to_bytes("01"), to_bytes("02"));
    compare_versions(to_bytes("011"), to_bytes("012"));
  endtask

  task automatic test_integral_context();
    compare_versions(to_bytes("1"), to_bytes("1"));
    compare_versions(to_bytes("5"), to_bytes("5x"));
  endtask

  task automatic test_random_versions(input int count);
    int stop;
    stop = pairs_sent + count;
    while (pairs_sent < stop) begin
      if ($urandom_range(99) < 12) begin
        // raw bytes, often leaving a comparison half done
        repeat ($urandom_range(1, 3)) send_pair(8'($urandom), 8'($urandom));
      end else begin
        random_comparison();
      end
    end
  endtask

  task automatic test_drained_restart();
    repeat (4) random_comparison();
    hold_sender();
    while (pending_orders.size() != 0) @(posedge clk);
    repeat (4) random_comparison();
  endtask

  always @(negedge clk) order_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (!rst && order_valid && order_ready) begin
      if (pending_orders.size() == 0) begin
        report_mismatch($sformatf("order %0d with no comparison pending", order));
      end else begin
        oldest_order = pending_orders.pop_front();
        if (order !== oldest_order)
          report_mismatch($sformatf("order %0d, expected %0d", order, oldest_order));
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_ends_and_extremes();
    test_digit_runs();
    test_leading_zeros();
    test_integral_context();

    send_idle_pct = 25;
    recv_idle_pct = 66;
    test_random_versions(140);
    send_idle_pct = 66;
    recv_idle_pct = 25;
    test_random_versions(140);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_versions(130);
    test_drained_restart();

    hold_sender();
    while (pending_orders.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) $display("tb_version_string_compare: done, clean");
    else $display("tb_version_string_compare: done, errors");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_version_string_compare: done, errors");
    $finish;
  end

endmodule
